// ===== rtl/core/sobel_pkg.sv =====
// Shared constants for the Sobel edge threshold block.
package sobel_pkg;

  // Field widths
  localparam int PIX_W      = 8;
  localparam int ROWS_W     = 12;
  localparam int COLS_W     = 12;
  localparam int THR_W      = 11;
  localparam int COLS_CMP_W = 13;   // holds any column limit up to 4096
  localparam int ROWS_CMP_W = 13;

  // Configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 12;

  localparam logic [CFG_IDX_W-1:0] CFG_REG_FRAME_ROWS     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_REG_FRAME_COLS     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_REG_EDGE_THRESHOLD = 2'd2;

  // Register reset values
  localparam logic [ROWS_W-1:0] FRAME_ROWS_RST     = 12'd480;
  localparam logic [COLS_W-1:0] FRAME_COLS_RST     = 12'd640;
  localparam logic [THR_W-1:0]  EDGE_THRESHOLD_RST = 11'd75;

  // Line store depth
  localparam int LINE_WIDTH_MAX_DEF = 2048;

  // Result codes and window start
  localparam logic [PIX_W-1:0] EDGE_ON   = 8'd255;
  localparam logic [PIX_W-1:0] EDGE_OFF  = 8'd0;
  localparam int               WIN_START = 2;

  // Gradient and magnitude widths
  localparam int GRAD_W = 11;   // signed, |G| <= 1020
  localparam int SQ_W   = 20;   // G^2 <= 1040400
  localparam int MAG_W  = 21;   // Gx^2 + Gy^2
  localparam int LIM_W  = 23;   // (threshold + 1)^2 <= 2^22

endpackage

// ===== rtl/core/sobel_if.sv =====
// Stream and configuration channel interfaces for the Sobel edge threshold block.
interface sobel_pix_if;
  logic                        valid;
  logic                        ready;
  logic [sobel_pkg::PIX_W-1:0] pixel;
  modport source (output valid, output pixel, input ready);
  modport sink (input valid, input pixel, output ready);
endinterface

interface sobel_res_if;
  logic                        valid;
  logic                        ready;
  logic [sobel_pkg::PIX_W-1:0] edge_value;
  logic                        frame_last;
  modport source (output valid, output edge_value, output frame_last, input ready);
  modport sink (input valid, input edge_value, input frame_last, output ready);
endinterface

interface sobel_cfg_if;
  logic                             valid;
  logic                             ready;
  logic [sobel_pkg::CFG_IDX_W-1:0]  index;
  logic [sobel_pkg::CFG_DATA_W-1:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

// ===== rtl/core/sobel_edge_threshold.sv =====
// Sobel edge detector with magnitude threshold. Pixels enter one per clock in
// raster order on in_pix; every pixel from row 2 and column 2 onward yields
// one result on out_res: 255 when Gx^2 + Gy^2 >= (edge_threshold + 1)^2, else
// 0, with frame_last set on the result at the last row and last column of the
// frame. Pixels in rows 0 and 1, and in columns 0 and 1, fill the line store
// and window and produce no result. The block accepts one pixel every clock
// cycle unless back-pressure from out_res fills the stages; that rate is set
// by the line store, a single memory of LINE_WIDTH_MAX words of 16 bits that
// is read once and written once per pixel, with a bypass for a read and write
// to the same column in the same cycle. The stages are line store read, window
// shift and gradients, squares, then compare into the output register. Each
// stage holds independently, so a result waiting on out_res does not stop
// input transactions until all stages are full. The configuration port is
// always ready; write registers only while no transaction is in flight. The
// line store needs no clearing after reset.
module sobel_edge_threshold #(
  parameter int LINE_WIDTH_MAX = sobel_pkg::LINE_WIDTH_MAX_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  sobel_pix_if.sink          in_pix,
  sobel_res_if.source        out_res,
  sobel_cfg_if.sink          cfg_wr
);

  localparam int CW   = (LINE_WIDTH_MAX > 2) ? $clog2(LINE_WIDTH_MAX) : 1;
  localparam int CCW  = sobel_pkg::COLS_CMP_W;
  localparam int RCW  = sobel_pkg::ROWS_CMP_W;
  localparam int PW   = sobel_pkg::PIX_W;
  localparam int GW   = sobel_pkg::GRAD_W;
  localparam int LW   = 2 * PW;

  // Configuration registers
  logic [sobel_pkg::ROWS_W-1:0] frame_rows_r;
  logic [sobel_pkg::COLS_W-1:0] frame_cols_r;
  logic [sobel_pkg::THR_W-1:0]  edge_threshold_r;
  logic [sobel_pkg::LIM_W-1:0]  lim_r;

  // Position counters
  logic [CW-1:0]                col_r;
  logic [sobel_pkg::ROWS_W-1:0] row_r;

  // Line store and its bypass
  logic [LW-1:0] line_mem [LINE_WIDTH_MAX];
  logic [LW-1:0] rdata_r;
  logic          byp_r;
  logic [LW-1:0] byp_data_r;

  // Stage B: pixel with its line store read
  logic          b_v_r;
  logic [PW-1:0] b_px_r;
  logic [CW-1:0] b_addr_r;
  logic          b_shift_r;
  logic          b_res_r;
  logic          b_last_r;

  // Window, top row oldest image row, column 0 oldest image column
  logic [PW-1:0] win_r [3][3];

  // Stage C: gradients
  logic                 c_v_r;
  logic signed [GW-1:0] c_gx_r;
  logic signed [GW-1:0] c_gy_r;
  logic                 c_last_r;

  // Stage D: squared magnitude
  logic                         d_v_r;
  logic [sobel_pkg::MAG_W-1:0]  d_mag_r;
  logic                         d_last_r;

  // Output register
  logic          out_valid_r;
  logic [PW-1:0] out_edge_r;
  logic          out_last_r;

  // ---------------------------------------------------------------------
  // Handshake: each stage loads when it is empty or its content moves on.
  // ---------------------------------------------------------------------
  logic o_rdy, d_rdy, c_rdy, b_fire, in_fire;

  assign o_rdy   = !out_valid_r || out_res.ready;
  assign d_rdy   = !d_v_r || o_rdy;
  assign c_rdy   = !c_v_r || d_rdy;
  // An item with no result drops out of stage B without waiting on stage C.
  assign b_fire  = b_v_r && (!b_res_r || c_rdy);
  assign in_pix.ready = !b_v_r || b_fire;
  assign in_fire = in_pix.valid && in_pix.ready;

  assign cfg_wr.ready = 1'b1;

  // ---------------------------------------------------------------------
  // Effective frame limits and position of the incoming pixel
  // ---------------------------------------------------------------------
  logic [CCW-1:0] cols_ext, cols_eff, col_p1;
  logic [RCW-1:0] rows_eff, row_p1;
  logic [CW-1:0]  col_use;
  logic           col_wrap, row_wrap;

  always_comb begin
    cols_ext = CCW'(frame_cols_r);
    if (cols_ext == '0) begin
      cols_eff = CCW'(1);
    end else if (cols_ext > CCW'(LINE_WIDTH_MAX)) begin
      cols_eff = CCW'(LINE_WIDTH_MAX);
    end else begin
      cols_eff = cols_ext;
    end
    rows_eff = (frame_rows_r == '0) ? RCW'(1) : RCW'(frame_rows_r);

    // Clamp a column left beyond a shrunken limit to the last column.
    if (CCW'(col_r) >= cols_eff) begin
      col_use = CW'(cols_eff - CCW'(1));
    end else begin
      col_use = col_r;
    end
    col_p1   = CCW'(col_use) + CCW'(1);
    row_p1   = RCW'(row_r) + RCW'(1);
    col_wrap = (col_p1 >= cols_eff);
    row_wrap = (row_p1 >= rows_eff);
  end

  // Configuration writes; an index beyond the list is dropped.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_rows_r     <= sobel_pkg::FRAME_ROWS_RST;
      frame_cols_r     <= sobel_pkg::FRAME_COLS_RST;
      edge_threshold_r <= sobel_pkg::EDGE_THRESHOLD_RST;
    end else if (cfg_wr.valid && cfg_wr.ready) begin
      case (cfg_wr.index)
        sobel_pkg::CFG_REG_FRAME_ROWS: frame_rows_r <= cfg_wr.data[sobel_pkg::ROWS_W-1:0];
        sobel_pkg::CFG_REG_FRAME_COLS: frame_cols_r <= cfg_wr.data[sobel_pkg::COLS_W-1:0];
        sobel_pkg::CFG_REG_EDGE_THRESHOLD: begin
          edge_threshold_r <= cfg_wr.data[sobel_pkg::THR_W-1:0];
        end
        default: ;
      endcase
    end
  end

  // Squared limit, refreshed every cycle from the threshold register.
  logic [sobel_pkg::THR_W:0]     thr_p1;
  logic [2*sobel_pkg::THR_W+1:0] lim_full;
  assign thr_p1   = {1'b0, edge_threshold_r} + (sobel_pkg::THR_W + 1)'(1);
  assign lim_full = thr_p1 * thr_p1;

  always_ff @(posedge clk) begin
    lim_r <= lim_full[sobel_pkg::LIM_W-1:0];
  end

  // Advance counters once per input transaction; wrap at row and frame end.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
    end else if (in_fire) begin
      if (col_wrap) begin
        col_r <= '0;
        row_r <= row_wrap ? '0 : row_p1[sobel_pkg::ROWS_W-1:0];
      end else begin
        col_r <= col_p1[CW-1:0];
      end
    end
  end

  // ---------------------------------------------------------------------
  // Line store: read at accept, write back when the item leaves stage B.
  // ---------------------------------------------------------------------
  logic [PW-1:0] b_up1, b_up2;
  logic [LW-1:0] wr_data;

  assign b_up1   = byp_r ? byp_data_r[PW-1:0]  : rdata_r[PW-1:0];
  assign b_up2   = byp_r ? byp_data_r[LW-1:PW] : rdata_r[LW-1:PW];
  assign wr_data = {b_up1, b_px_r};

  always_ff @(posedge clk) begin
    if (b_fire) begin
      line_mem[b_addr_r] <= wr_data;
    end
    if (in_fire) begin
      rdata_r <= line_mem[col_use];
    end
  end

  // Forward a write that lands in the same cycle as a read of that column.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      byp_r      <= b_fire && (b_addr_r == col_use);
      byp_data_r <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_v_r <= 1'b0;
    end else if (in_pix.ready) begin
      b_v_r <= in_pix.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      b_px_r    <= in_pix.pixel;
      b_addr_r  <= col_use;
      b_shift_r <= (RCW'(row_r) >= RCW'(sobel_pkg::WIN_START));
      b_res_r   <= (RCW'(row_r) >= RCW'(sobel_pkg::WIN_START))
                && (CCW'(col_use) >= CCW'(sobel_pkg::WIN_START));
      b_last_r  <= row_wrap && col_wrap;
    end
  end

  // ---------------------------------------------------------------------
  // Window shift and Sobel gradients
  // ---------------------------------------------------------------------
  logic [PW-1:0]        win_nxt [3][3];
  logic signed [GW-1:0] n [3][3];
  logic signed [GW-1:0] gx_nxt, gy_nxt;

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      win_nxt[r][0] = win_r[r][1];
      win_nxt[r][1] = win_r[r][2];
    end
    win_nxt[0][2] = b_up2;
    win_nxt[1][2] = b_up1;
    win_nxt[2][2] = b_px_r;
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        n[r][c] = $signed({(GW - PW)'(0), win_nxt[r][c]});
      end
    end
    gx_nxt = (n[0][2] - n[0][0]) + ((n[1][2] - n[1][0]) <<< 1) + (n[2][2] - n[2][0]);
    gy_nxt = (n[2][0] - n[0][0]) + ((n[2][1] - n[0][1]) <<< 1) + (n[2][2] - n[0][2]);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int r = 0; r < 3; r++) begin
        for (int c = 0; c < 3; c++) begin
          win_r[r][c] <= '0;
        end
      end
    end else if (b_fire && b_shift_r) begin
      win_r <= win_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c_v_r <= 1'b0;
    end else if (c_rdy) begin
      c_v_r <= b_v_r && b_res_r;
    end
  end

  always_ff @(posedge clk) begin
    if (c_rdy) begin
      c_gx_r   <= gx_nxt;
      c_gy_r   <= gy_nxt;
      c_last_r <= b_last_r;
    end
  end

  // ---------------------------------------------------------------------
  // Squares and compare
  // ---------------------------------------------------------------------
  logic signed [2*GW-1:0]       gx_sq, gy_sq;
  logic [sobel_pkg::MAG_W-1:0]  mag_nxt;

  assign gx_sq   = c_gx_r * c_gx_r;
  assign gy_sq   = c_gy_r * c_gy_r;
  assign mag_nxt = sobel_pkg::MAG_W'(gx_sq[sobel_pkg::SQ_W-1:0])
                 + sobel_pkg::MAG_W'(gy_sq[sobel_pkg::SQ_W-1:0]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      d_v_r <= 1'b0;
    end else if (d_rdy) begin
      d_v_r <= c_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (d_rdy) begin
      d_mag_r  <= mag_nxt;
      d_last_r <= c_last_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (o_rdy) begin
      out_valid_r <= d_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (o_rdy) begin
      out_edge_r <= (sobel_pkg::LIM_W'(d_mag_r) >= lim_r) ? sobel_pkg::EDGE_ON
                                                           : sobel_pkg::EDGE_OFF;
      out_last_r <= d_last_r;
    end
  end

  assign out_res.valid      = out_valid_r;
  assign out_res.edge_value = out_edge_r;
  assign out_res.frame_last = out_last_r;

endmodule

// ===== sim/sobel_edge_threshold_test.sv =====
// Self-checking testbench for the Sobel edge threshold block: directed and random frames.
`timescale 1ns / 100ps

module sobel_edge_threshold_test;

  localparam int LINE_DEPTH    = sobel_pkg::LINE_WIDTH_MAX_DEF;
  localparam int RANDOM_PIXELS = 850;
  // The pipeline is four stages deep; give pixels that make no result time
  // to leave it before any register write.
  localparam int DRAIN_CYCLES  = 12;
  localparam int STALL_LIMIT   = 5000;
  // Index past the register list: the block must ignore writes to it.
  localparam logic [sobel_pkg::CFG_IDX_W-1:0] CFG_REG_UNUSED = 2'd3;

  typedef struct packed {
    logic [sobel_pkg::PIX_W-1:0] edge_value;
    logic                        frame_last;
  } edge_result_t;

  // Image content per frame: full noise, black/white, nearly flat, slow ramp.
  typedef enum int {STYLE_NOISE, STYLE_BINARY, STYLE_FLAT, STYLE_RAMP} pixel_style_t;

  logic clk;
  logic rst_n;

  sobel_pix_if in_pix();
  sobel_res_if out_res();
  sobel_cfg_if cfg_wr();

  sobel_edge_threshold dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_pix (in_pix),
    .out_res(out_res),
    .cfg_wr (cfg_wr)
  );

  // Predictor state: a private copy of line history, window, raster position
  // and registers, advanced once per accepted pixel transaction.
  logic [15:0]                  line_hist [LINE_DEPTH];
  logic [sobel_pkg::PIX_W-1:0]  win [3][3];
  int unsigned                  row_pos;
  int unsigned                  col_pos;
  logic [sobel_pkg::ROWS_W-1:0] rows_reg;
  logic [sobel_pkg::COLS_W-1:0] cols_reg;
  logic [sobel_pkg::THR_W-1:0]  thr_reg;

  edge_result_t                 edges_due [$];
  int unsigned                  mismatches;
  int unsigned                  pixels_sent;
  int unsigned                  send_idle_pct;
  int unsigned                  recv_stall_pct;
  pixel_style_t                 style;
  logic [sobel_pkg::PIX_W-1:0]  ramp_level;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Work out the result of one accepted pixel, if any, and queue it.
  task automatic predict_pixel(input logic [sobel_pkg::PIX_W-1:0] px);
    int unsigned                 cols;
    int unsigned                 rows;
    int unsigned                 col;
    int unsigned                 row;
    int unsigned                 slot;
    int unsigned                 mag2;
    int unsigned                 lim;
    int                          gx;
    int                          gy;
    int                          w [3][3];
    int                          r;
    int                          c;
    logic [sobel_pkg::PIX_W-1:0] up2;
    logic [sobel_pkg::PIX_W-1:0] up1;
    edge_result_t                res;
    // Clamp the sizes the way the block does: zero acts as one, and the
    // column count never exceeds the line store.
    cols = (cols_reg == 0) ? 1 : cols_reg;
    if (cols > LINE_DEPTH) cols = LINE_DEPTH;
    rows = (rows_reg == 0) ? 1 : rows_reg;
    col  = (col_pos >= cols) ? cols - 1 : col_pos;
    row  = row_pos;
    slot = col % LINE_DEPTH;
    {up2, up1} = line_hist[slot];
    line_hist[slot] = {up1, px};
    if (row >= sobel_pkg::WIN_START) begin
      for (r = 0; r < 3; r++) begin
        for (c = 0; c < 2; c++) win[r][c] = win[r][c + 1];
      end
      win[0][2] = up2;
      win[1][2] = up1;
      win[2][2] = px;
      if (col >= sobel_pkg::WIN_START) begin
        for (r = 0; r < 3; r++) begin
          for (c = 0; c < 3; c++) w[r][c] = win[r][c];
        end
        gx = -w[0][0] + w[0][2] - 2 * w[1][0] + 2 * w[1][2] - w[2][0] + w[2][2];
        gy = -w[0][0] - 2 * w[0][1] - w[0][2] + w[2][0] + 2 * w[2][1] + w[2][2];
        mag2 = gx * gx + gy * gy;
        lim  = (int'(thr_reg) + 1) * (int'(thr_reg) + 1);
        res.edge_value = (mag2 >= lim) ? sobel_pkg::EDGE_ON : sobel_pkg::EDGE_OFF;
        res.frame_last = (row + 1 >= rows) && (col + 1 >= cols);
        edges_due.push_back(res);
      end
    end
    // Wrap counters at the end of a row and at the end of the frame.
    if (col + 1 >= cols) begin
      col_pos = 0;
      row_pos = (row + 1 >= rows) ? 0 : ((row + 1) & 12'hFFF);
    end else begin
      col_pos = (col + 1) & 11'h7FF;
    end
  endtask

  function automatic logic [sobel_pkg::PIX_W-1:0] next_pixel();
    case (style)
      STYLE_BINARY: return ($urandom_range(1) != 0) ? 8'hFF : 8'h00;
      STYLE_FLAT:   return {ramp_level[7:3], 3'($urandom_range(7))};
      STYLE_RAMP: begin
        ramp_level += 8'($urandom_range(1, 9));
        return ramp_level;
      end
      default:      return 8'($urandom);
    endcase
  endfunction

  // Offer one pixel, idling first at random; keep valid high on return so
  // back-to-back transactions go out on consecutive cycles.
  task automatic send_pixel(input logic [sobel_pkg::PIX_W-1:0] px);
    while ($urandom_range(99) < send_idle_pct) begin
      in_pix.valid <= 1'b0;
      @(posedge clk);
    end
    in_pix.valid <= 1'b1;
    in_pix.pixel <= px;
    @(posedge clk);
    while (in_pix.ready !== 1'b1) @(posedge clk);
    predict_pixel(px);
    pixels_sent++;
  endtask

  // Feed pixels until the raster is back at the frame start. Called at the
  // frame start, this sends one whole frame.
  task automatic send_frame();
    do send_pixel(next_pixel());
    while (!(row_pos == 0 && col_pos == 0));
  endtask

  // Hold the input until every queued result has arrived and the pipeline
  // has emptied of pixels that make none.
  task automatic drain_pipeline();
    in_pix.valid <= 1'b0;
    @(posedge clk);
    while (edges_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic cfg_write(input logic [sobel_pkg::CFG_IDX_W-1:0] idx,
                           input logic [sobel_pkg::CFG_DATA_W-1:0] data);
    cfg_wr.valid <= 1'b1;
    cfg_wr.index <= idx;
    cfg_wr.data  <= data;
    @(posedge clk);
    while (cfg_wr.ready !== 1'b1) @(posedge clk);
    case (idx)
      sobel_pkg::CFG_REG_FRAME_ROWS:     rows_reg = data[sobel_pkg::ROWS_W-1:0];
      sobel_pkg::CFG_REG_FRAME_COLS:     cols_reg = data[sobel_pkg::COLS_W-1:0];
      sobel_pkg::CFG_REG_EDGE_THRESHOLD: thr_reg  = data[sobel_pkg::THR_W-1:0];
      default: ;
    endcase
    cfg_wr.valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_idling(input int unsigned send_pct, input int unsigned stall_pct);
    send_idle_pct  = send_pct;
    recv_stall_pct = stall_pct;
  endtask

  // Run the reset sizes and threshold: one full row of 640, then shrink the
  // frame to three rows of 40 and finish it at the reset threshold.
  task automatic test_reset_values();
    set_idling(0, 0);
    style = STYLE_NOISE;
    repeat (640) send_pixel(next_pixel());
    drain_pipeline();
    cfg_write(sobel_pkg::CFG_REG_FRAME_ROWS, 12'd3);
    cfg_write(sobel_pkg::CFG_REG_FRAME_COLS, 12'd40);
    send_frame();
    drain_pipeline();
  endtask

  // Sizes that never make a result: zero rows, zero columns, two of each.
  // Also write past the register list.
  task automatic test_degenerate_sizes();
    set_idling(18, 18);
    style = STYLE_BINARY;
    cfg_write(sobel_pkg::CFG_REG_EDGE_THRESHOLD, 12'd0);
    cfg_write(sobel_pkg::CFG_REG_FRAME_ROWS, 12'd0);
    cfg_write(sobel_pkg::CFG_REG_FRAME_COLS, 12'd3);
    send_frame();
    drain_pipeline();
    cfg_write(sobel_pkg::CFG_REG_FRAME_ROWS, 12'd3);
    cfg_write(sobel_pkg::CFG_REG_FRAME_COLS, 12'd0);
    send_frame();
    drain_pipeline();
    cfg_write(sobel_pkg::CFG_REG_FRAME_ROWS, 12'd2);
    cfg_write(sobel_pkg::CFG_REG_FRAME_COLS, 12'd2);
    send_frame();
    drain_pipeline();
    cfg_write(CFG_REG_UNUSED, 12'hFFF);
  endtask

  // A vertical step gives |Gx| = 1020 exactly: an edge at threshold 1019,
  // none at 1020. The column after the step has a zero gradient.
  task automatic test_threshold_limits();
    logic [sobel_pkg::PIX_W-1:0] step_row [4];
    step_row = '{8'h00, 8'h00, 8'hFF, 8'h00};
    set_idling(0, 0);
    cfg_write(sobel_pkg::CFG_REG_FRAME_ROWS, 12'd3);
    cfg_write(sobel_pkg::CFG_REG_FRAME_COLS, 12'd4);
    cfg_write(sobel_pkg::CFG_REG_EDGE_THRESHOLD, 12'd1019);
    repeat (3) foreach (step_row[i]) send_pixel(step_row[i]);
    drain_pipeline();
    cfg_write(sobel_pkg::CFG_REG_EDGE_THRESHOLD, 12'd1020);
    repeat (3) foreach (step_row[i]) send_pixel(step_row[i]);
    drain_pipeline();
  endtask

  // Shrink the row count below the current row, then the column count below
  // the current column; the row must wrap at its end and the column at the next pixel.
  task automatic test_resize_mid_frame();
    set_idling(18, 18);
    style = STYLE_NOISE;
    cfg_write(sobel_pkg::CFG_REG_EDGE_THRESHOLD, 12'd150);
    cfg_write(sobel_pkg::CFG_REG_FRAME_ROWS, 12'hFFF);
    cfg_write(sobel_pkg::CFG_REG_FRAME_COLS, 12'd5);
    repeat (25) send_pixel(next_pixel());
    drain_pipeline();
    cfg_write(sobel_pkg::CFG_REG_FRAME_ROWS, 12'd3);
    send_frame();
    drain_pipeline();
    cfg_write(sobel_pkg::CFG_REG_FRAME_ROWS, 12'd4);
    cfg_write(sobel_pkg::CFG_REG_FRAME_COLS, 12'd9);
    repeat (2 * 9 + 6) send_pixel(next_pixel());
    drain_pipeline();
    cfg_write(sobel_pkg::CFG_REG_FRAME_COLS, 12'd4);
    send_frame();
    drain_pipeline();
  endtask

  // New sizes are chosen only at a frame start, so a wider frame always
  // refills the line history before reading it.
  task automatic pick_frame_setup();
    logic [sobel_pkg::CFG_DATA_W-1:0] rows;
    logic [sobel_pkg::CFG_DATA_W-1:0] cols;
    logic [sobel_pkg::CFG_DATA_W-1:0] thr;
    rows = ($urandom_range(9) == 0) ? 12'($urandom_range(2)) : 12'($urandom_range(3, 8));
    case ($urandom_range(19))
      0:       cols = 12'($urandom_range(2));
      1, 2:    cols = 12'($urandom_range(17, 64));
      default: cols = 12'($urandom_range(3, 16));
    endcase
    thr = ($urandom_range(3) == 0) ? 12'($urandom_range(4095)) : 12'($urandom_range(300));
    style      = pixel_style_t'($urandom_range(3));
    ramp_level = 8'($urandom);
    cfg_write(sobel_pkg::CFG_REG_EDGE_THRESHOLD, thr);
    cfg_write(sobel_pkg::CFG_REG_FRAME_ROWS, rows);
    cfg_write(sobel_pkg::CFG_REG_FRAME_COLS, cols);
    if ($urandom_range(7) == 0) cfg_write(CFG_REG_UNUSED, 12'($urandom));
  endtask

  // Random frames in four idling phases: none, sender idle, receiver
  // stalling, both.
  task automatic test_random_frames();
    int unsigned first;
    int unsigned phase;
    first = pixels_sent;
    while (pixels_sent - first < RANDOM_PIXELS) begin
      phase = (pixels_sent - first) * 4 / RANDOM_PIXELS;
      case (phase)
        0:       set_idling(0, 0);
        1:       set_idling(76, 0);
        2:       set_idling(0, 76);
        default: set_idling(18, 18);
      endcase
      drain_pipeline();
      pick_frame_setup();
      repeat ($urandom_range(1, 3)) send_frame();
    end
    drain_pipeline();
  endtask

  // Randomize the result ready every cycle at the current stall rate.
  always @(posedge clk) begin
    out_res.ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Compare each result transaction with the oldest queued expectation.
  always @(posedge clk) begin
    edge_result_t want;
    if (rst_n === 1'b1 && out_res.valid === 1'b1 && out_res.ready === 1'b1) begin
      if (edges_due.size() == 0) begin
        $display("%0t: unexpected result, expected none, got edge_value=%0d frame_last=%0b",
                 $time, out_res.edge_value, out_res.frame_last);
        mismatches++;
      end else begin
        want = edges_due.pop_front();
        if (out_res.edge_value !== want.edge_value) begin
          $display("%0t: edge_value mismatch, expected %0d, got %0d",
                   $time, want.edge_value, out_res.edge_value);
          mismatches++;
        end
        if (out_res.frame_last !== want.frame_last) begin
          $display("%0t: frame_last mismatch, expected %0b, got %0b",
                   $time, want.frame_last, out_res.frame_last);
          mismatches++;
        end
      end
    end
  end

  // Abort when no transaction of any kind has completed for too long.
  initial begin
    int unsigned quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_pix.valid === 1'b1 && in_pix.ready === 1'b1) ||
          (out_res.valid === 1'b1 && out_res.ready === 1'b1) ||
          (cfg_wr.valid === 1'b1 && cfg_wr.ready === 1'b1))
        quiet = 0;
      else
        quiet++;
    end
    $display("%0t: no transaction for %0d cycles", $time, STALL_LIMIT);
    $display("sobel_edge_threshold_test NOT OK");
    $finish;
  end

  initial begin
    rst_n         <= 1'b0;
    in_pix.valid  <= 1'b0;
    in_pix.pixel  <= '0;
    cfg_wr.valid  <= 1'b0;
    cfg_wr.index  <= sobel_pkg::CFG_REG_FRAME_ROWS;
    cfg_wr.data   <= '0;
    // Predictor starts from the reset state of the block.
    foreach (line_hist[i]) line_hist[i] = '0;
    foreach (win[r, c]) win[r][c] = '0;
    row_pos        = 0;
    col_pos        = 0;
    rows_reg       = sobel_pkg::FRAME_ROWS_RST;
    cols_reg       = sobel_pkg::FRAME_COLS_RST;
    thr_reg        = sobel_pkg::EDGE_THRESHOLD_RST;
    mismatches     = 0;
    pixels_sent    = 0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    style          = STYLE_NOISE;
    ramp_level     = '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_values();
    test_degenerate_sizes();
    test_threshold_limits();
    test_resize_mid_frame();
    test_random_frames();

    drain_pipeline();
    if (mismatches == 0 && edges_due.size() == 0) begin
      $display("sobel_edge_threshold_test OK");
    end else begin
      $display("sobel_edge_threshold_test NOT OK");
    end
    $finish;
  end

endmodule
